@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ sv/pcsv_pkg.sv @@
// Package with constants, codes and helper functions of the PNG chunk validator.
package pcsv_pkg;
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_NAME = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_HALT = 3'd5;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_PNG   = 4'd1;
  localparam logic [3:0] ST_TRUNC     = 4'd2;
  localparam logic [3:0] ST_OVERSIZE  = 4'd3;
  localparam logic [3:0] ST_NAME_CRC  = 4'd4;
  localparam logic [3:0] ST_NO_IHDR   = 4'd5;
  localparam logic [3:0] ST_BAD_IHDR  = 4'd6;
  localparam logic [3:0] ST_META      = 4'd7;
  localparam logic [3:0] ST_PALETTE   = 4'd8;
  localparam logic [3:0] ST_DAT_ORDER = 4'd9;
  localparam logic [3:0] ST_TERM      = 4'd10;
  localparam logic [3:0] ST_ANIMATED  = 4'd11;
  localparam logic [3:0] ST_UNK_CRIT  = 4'd12;
  localparam logic [3:0] ST_NO_IEND   = 4'd13;

  localparam logic [0:0] REG_EXP_WIDTH  = 1'd0;
  localparam logic [0:0] REG_EXP_HEIGHT = 1'd1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] MAX_DIM = 32'd16384;
  localparam logic [31:0] MAX_PAL = 32'd768;
  localparam logic [5:0] MIN_FILE = 6'd57;

  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_PLTE = 32'h504C5445;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] TAG_ACTL = 32'h6163544C;
  localparam logic [31:0] TAG_FCTL = 32'h6663544C;
  localparam logic [31:0] TAG_FDAT = 32'h66644154;

  typedef struct packed {
    logic hdr;
    logic pal;
    logic dat;
    logic ended;
    logic nonzero;
    logic done;
  } seen_t;

  // Per-chunk verdict handed from the judge to the top level.
  typedef struct packed {
    logic [3:0] err;
    seen_t      seen;
    logic       halt;
    logic       hdr_capture;
    logic       hdr_accept;
  } verdict_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction
endpackage

@@ sv/png_chunk_stream_validator_core.sv @@
// Top level of the PNG chunk stream validator.
// The block takes one PNG file as a stream of byte words, one word per cycle with no
// bubbles of its own, and gives a single verdict word in the cycle after the word that
// carries last_byte. Each accepted byte passes through one register stage of parsing:
// the byte-wide CRC-32 update and the chunk judgment are both combinational ahead of it, so the
// sustained rate is one byte per clock. The verdict sits in an output register; the
// block accepts bytes whenever that register is empty or being taken, and stalls its
// input in every cycle in which a verdict waits and the receiver holds it off.
// After each verdict all per-file state returns to its reset value; expected_width and
// expected_height persist.
// Files shorter than 57 bytes always report status 1 with zero fields.
module png_chunk_stream_validator_core import pcsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [31:0] width,
  output logic [31:0] height,
  output logic [4:0]  bit_depth,
  output logic [2:0]  colour_kind
);
`include "assert_macros.svh"

  logic [14:0] exp_w, exp_h;
  logic [5:0]  file_count;
  logic [2:0]  phase;
  logic [31:0] pos, len, tag, crc, scrc;
  logic [31:0] hdr_w, hdr_h;
  logic [4:0]  hdr_d;
  logic [2:0]  hdr_k;
  seen_t       seen;
  logic [3:0]  err;
  logic [7:0]  cap [13];

  logic [5:0]  file_count_next;
  logic [2:0]  phase_next;
  logic [31:0] pos_next, len_next, tag_next, crc_next, scrc_next;
  seen_t       seen_next;
  logic [3:0]  err_next;
  logic [31:0] crc_upd, pos_inc, scrc_shift;
  logic [3:0]  status_next;
  logic        accept;
  verdict_t    v;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign pos_inc = pos + 32'd1;
  assign scrc_shift = {scrc[23:0], data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_w <= '0;
      exp_h <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXP_WIDTH:  exp_w <= cfg_data;
        REG_EXP_HEIGHT: exp_h <= cfg_data;
        default: ;
      endcase
    end
  end

  pcsv_crc8 u_crc (.crc(crc), .data(data_byte), .crc_next(crc_upd));

  pcsv_judge u_judge (
    .tag(tag), .len(len), .crc_calc(crc), .crc_stored(scrc_shift), .seen(seen),
    .colour(hdr_k),
    .cap_w({cap[0], cap[1], cap[2], cap[3]}), .cap_h({cap[4], cap[5], cap[6], cap[7]}),
    .cap_d(cap[8]), .cap_k(cap[9]), .cap_tail({cap[10], cap[11], cap[12]}),
    .exp_w(exp_w), .exp_h(exp_h), .last(last_byte), .v(v)
  );

  // Parsing step for one byte; the chunk verdict is taken on the last CRC byte.
  always_comb begin
    logic halt;
    file_count_next = (file_count < MIN_FILE) ? file_count + 6'd1 : file_count;
    phase_next = phase;
    pos_next = pos;
    len_next = len;
    tag_next = tag;
    crc_next = crc;
    scrc_next = scrc;
    seen_next = seen;
    err_next = err;
    halt = 1'b0;
    unique case (phase)
      PH_SIG: begin
        if (data_byte != sig_byte(pos[2:0])) begin
          halt = 1'b1;
          if (err == ST_OK) err_next = ST_NOT_PNG;
        end else if (pos_inc >= 32'd8) begin
          phase_next = PH_LEN; pos_next = '0;
        end else pos_next = pos_inc;
      end
      PH_LEN: begin
        len_next = {len[23:0], data_byte};
        if (pos_inc >= 32'd4) begin
          phase_next = PH_NAME; pos_next = '0; tag_next = '0; crc_next = CRC_INIT;
        end else pos_next = pos_inc;
      end
      PH_NAME: begin
        tag_next = {tag[23:0], data_byte};
        crc_next = crc_upd;
        if (pos_inc >= 32'd4) begin
          phase_next = (len != 32'd0) ? PH_PAY : PH_CRC;
          pos_next = '0; scrc_next = '0;
        end else pos_next = pos_inc;
      end
      PH_PAY: begin
        crc_next = crc_upd;
        if (pos_inc == len) begin
          phase_next = PH_CRC; pos_next = '0;
        end else pos_next = pos_inc;
      end
      PH_CRC: begin
        scrc_next = scrc_shift;
        if (pos_inc >= 32'd4) begin
          seen_next = v.seen;
          if (err == ST_OK) err_next = v.err;
          phase_next = v.halt ? PH_HALT : PH_LEN;
          pos_next = '0; len_next = '0;
        end else pos_next = pos_inc;
      end
      default: ;
    endcase
    if (halt) phase_next = PH_HALT;
  end

  // Verdict as the file would stand after this byte.
  always_comb begin
    logic [32:0] got;
    got = '0;
    unique case (phase_next)
      PH_LEN:  got = {1'b0, pos_next};
      PH_NAME: got = 33'd4 + {1'b0, pos_next};
      PH_PAY:  got = 33'd8 + {1'b0, pos_next};
      default: got = 33'd8 + {1'b0, len_next} + {1'b0, pos_next};
    endcase
    if (file_count_next < MIN_FILE) status_next = ST_NOT_PNG;
    else if (err_next != ST_OK) status_next = err_next;
    else if (seen_next.done) status_next = ST_OK;
    else if (phase_next == PH_LEN && pos_next == 32'd0) status_next = ST_NO_IEND;
    else status_next = (got < 33'd12) ? ST_TRUNC : ST_OVERSIZE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_count <= '0; phase <= PH_SIG; pos <= '0; len <= '0; tag <= '0;
      crc <= CRC_INIT; scrc <= '0; seen <= '0; err <= ST_OK;
      hdr_w <= '0; hdr_h <= '0; hdr_d <= '0; hdr_k <= '0;
      out_valid <= 1'b0;
    end else begin
      // A waiting verdict stays until taken; a last byte loads a new one.
      out_valid <= (out_valid && out_stall) || (accept && last_byte);
      if (accept) begin
        if (last_byte) begin
          status <= status_next;
          if (status_next == ST_NOT_PNG) begin
            width <= '0; height <= '0; bit_depth <= '0; colour_kind <= '0;
          end else begin
            width  <= (phase == PH_CRC && v.hdr_capture && pos_inc >= 32'd4) ?
                      {cap[0], cap[1], cap[2], cap[3]} : hdr_w;
            height <= (phase == PH_CRC && v.hdr_capture && pos_inc >= 32'd4) ?
                      {cap[4], cap[5], cap[6], cap[7]} : hdr_h;
            bit_depth   <= (phase == PH_CRC && v.hdr_accept && pos_inc >= 32'd4) ?
                           cap[8][4:0] : hdr_d;
            colour_kind <= (phase == PH_CRC && v.hdr_accept && pos_inc >= 32'd4) ?
                           cap[9][2:0] : hdr_k;
          end
          file_count <= '0; phase <= PH_SIG; pos <= '0; len <= '0; tag <= '0;
          crc <= CRC_INIT; scrc <= '0; seen <= '0; err <= ST_OK;
          hdr_w <= '0; hdr_h <= '0; hdr_d <= '0; hdr_k <= '0;
        end else begin
          file_count <= file_count_next; phase <= phase_next; pos <= pos_next;
          len <= len_next; tag <= tag_next; crc <= crc_next; scrc <= scrc_next;
          seen <= seen_next; err <= err_next;
          if (phase == PH_CRC && pos_inc >= 32'd4 && v.hdr_capture) begin
            hdr_w <= {cap[0], cap[1], cap[2], cap[3]};
            hdr_h <= {cap[4], cap[5], cap[6], cap[7]};
          end
          if (phase == PH_CRC && pos_inc >= 32'd4 && v.hdr_accept) begin
            hdr_d <= cap[8][4:0];
            hdr_k <= cap[9][2:0];
          end
        end
      end
    end
  end

  // Payload capture of the first 13 bytes; cleared on reset and with each file's last byte.
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      for (int i = 0; i < 13; i++) cap[i] <= '0;
    end else if (accept && phase == PH_PAY && pos < 32'd13) begin
      cap[pos[3:0]] <= data_byte;
    end
  end

  `ASSERT_IMPLY(a_stall_only_full, clk, rst, in_stall, out_valid)
  `ASSERT_NEXT(a_last_gives_word, clk, rst, accept && last_byte, out_valid)
  `ASSERT_NEXT(a_clean_after_last, clk, rst, accept && last_byte,
               phase == PH_SIG && file_count == 6'd0 && err == ST_OK)
  `ASSERT_IMPLY(a_halt_has_reason, clk, rst, phase == PH_HALT, err != ST_OK || seen.done)
endmodule

@@ sv/pcsv_crc8.sv @@
// Byte-wide CRC-32 update, one byte folded per cycle.
module pcsv_crc8 import pcsv_pkg::*; (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_next
);
  always_comb begin
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_next = c;
  end
endmodule

@@ sv/pcsv_judge.sv @@
// Judgment of one completed chunk against name, CRC, header and ordering rules.
module pcsv_judge import pcsv_pkg::*; (
  input  logic [31:0] tag,
  input  logic [31:0] len,
  input  logic [31:0] crc_calc,
  input  logic [31:0] crc_stored,
  input  seen_t       seen,
  input  logic [2:0]  colour,
  input  logic [31:0] cap_w,
  input  logic [31:0] cap_h,
  input  logic [7:0]  cap_d,
  input  logic [7:0]  cap_k,
  input  logic [23:0] cap_tail,
  input  logic [14:0] exp_w,
  input  logic [14:0] exp_h,
  input  logic        last,
  output verdict_t    v
);
  function automatic logic letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  logic name_ok, is_hdr, is_dat, low_d, depth_ok, len3;

  assign name_ok = letter(tag[31:24]) && letter(tag[23:16]) && letter(tag[15:8]) &&
                   letter(tag[7:0]) && !tag[13];
  assign is_hdr = tag == TAG_IHDR;
  assign is_dat = tag == TAG_IDAT;
  assign low_d = cap_d == 8'd1 || cap_d == 8'd2 || cap_d == 8'd4 || cap_d == 8'd8;

  always_comb begin
    unique case (cap_k)
      8'd0: depth_ok = low_d || cap_d == 8'd16;
      8'd3: depth_ok = low_d;
      8'd2, 8'd4, 8'd6: depth_ok = cap_d == 8'd8 || cap_d == 8'd16;
      default: depth_ok = 1'b0;
    endcase
  end

  // Divisibility by three only matters for len <= 768: a 10-bit reciprocal check.
  always_comb begin
    logic [9:0] l;
    logic [9:0] q;
    l = len[9:0];
    q = 10'((20'(l) * 20'd683) >> 11);
    len3 = (10'(q * 10'd3) == l);
  end

  always_comb begin
    v = '0;
    v.seen = seen;
    if (!name_ok || (crc_calc ^ CRC_INIT) != crc_stored) begin
      v.err = ST_NAME_CRC; v.halt = 1'b1;
    end else if (!seen.hdr && !is_hdr) begin
      v.err = ST_NO_IHDR; v.halt = 1'b1;
    end else if (is_hdr) begin
      if (seen.hdr || len != 32'd13) begin
        v.err = ST_BAD_IHDR; v.halt = 1'b1;
      end else begin
        v.hdr_capture = 1'b1;
        if (cap_w == 32'd0 || cap_h == 32'd0 || cap_w > MAX_DIM || cap_h > MAX_DIM ||
            !depth_ok || cap_tail != 24'd0 ||
            (exp_w != 15'd0 && cap_w != {17'd0, exp_w}) ||
            (exp_h != 15'd0 && cap_h != {17'd0, exp_h})) begin
          v.err = ST_META; v.halt = 1'b1;
        end else begin
          v.hdr_accept = 1'b1;
          v.seen.hdr = 1'b1;
          if (seen.dat) v.seen.ended = 1'b1;
        end
      end
    end else if (tag == TAG_PLTE) begin
      if (seen.pal || seen.dat || len == 32'd0 || len > MAX_PAL || !len3 ||
          colour == 3'd0 || colour == 3'd4) begin
        v.err = ST_PALETTE; v.halt = 1'b1;
      end else begin
        v.seen.pal = 1'b1;
        if (seen.dat) v.seen.ended = 1'b1;
      end
    end else if (is_dat) begin
      if (seen.ended || (colour == 3'd3 && !seen.pal)) begin
        v.err = ST_DAT_ORDER; v.halt = 1'b1;
      end else begin
        v.seen.dat = 1'b1;
        if (len != 32'd0) v.seen.nonzero = 1'b1;
      end
    end else if (tag == TAG_IEND) begin
      if (len != 32'd0 || !seen.dat || !seen.nonzero || !last) begin
        v.err = ST_TERM; v.halt = 1'b1;
      end else begin
        v.seen.done = 1'b1; v.halt = 1'b1;
      end
    end else if (tag == TAG_ACTL || tag == TAG_FCTL || tag == TAG_FDAT) begin
      v.err = ST_ANIMATED; v.halt = 1'b1;
    end else begin
      if (seen.dat) v.seen.ended = 1'b1;
      if (!tag[29]) begin
        v.err = ST_UNK_CRIT; v.halt = 1'b1;
      end
    end
  end
endmodule
